// ===== design/clock_offset_latency_tracker_macros.svh =====
// assertion macros for the clock offset and latency tracker
// used by the top level only; the bodies are empty when SYNTHESIS is defined
`ifndef CLOCK_OFFSET_LATENCY_TRACKER_MACROS_SVH
`define CLOCK_OFFSET_LATENCY_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define CLT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clt assertion failed");
`define CLT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clt assertion failed");
`else
`define CLT_ASSERT_IMP(label, clk, rst, ante, cons)
`define CLT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/clt_pkg.sv =====
// shared types and constants for the clock offset and latency tracker
// no dependencies
`default_nettype none

package clt_pkg;

  localparam int DEF_COUNT_WIDTH = 32;
  localparam int TIME_W = 63;
  localparam int SUM_W = 64;
  localparam int STALE_W = 40;
  localparam int MEAN_W = 31;
  localparam logic [STALE_W-1:0] STALE_RESET = 40'd10000000000;

  // nanoseconds per millisecond, walked msb first by the divisor build
  localparam int MS_BITS = 20;
  localparam logic [MS_BITS-1:0] NS_PER_MS = 20'd1000000;
  localparam int MS_IDX_W = $clog2(MS_BITS);
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [1:0] KIND_SYNC = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SYNC_A,
    ST_SYNC_B,
    ST_FRAME_A,
    ST_FRAME_B,
    ST_FRAME_C,
    ST_TICK_CHK,
    ST_TICK_MUL,
    ST_DIV_INIT,
    ST_TICK_DIV,
    ST_TICK_END,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SYNC_A,
    OP_SYNC_B,
    OP_FRAME_A,
    OP_FRAME_B,
    OP_FRAME_C,
    OP_TICK_START,
    OP_MUL_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_TICK_END,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic [MS_IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic count_zero;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/clt_ctrl.sv =====
// controller state machine: sequences sync, frame and tick work in the datapath
// depends on clt_pkg
`default_nettype none

module clt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire clt_pkg::stat_t stat,
  output clt_pkg::cmd_t       cmd
);

  clt_pkg::state_t state, state_next;
  logic [clt_pkg::STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clt_pkg::ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      clt_pkg::ST_IDLE: begin
        if (in_valid) state_next = clt_pkg::ST_DISPATCH;
      end
      clt_pkg::ST_DISPATCH: begin
        unique case (stat.kind)
          clt_pkg::KIND_SYNC:  state_next = clt_pkg::ST_SYNC_A;
          clt_pkg::KIND_FRAME: state_next = clt_pkg::ST_FRAME_A;
          clt_pkg::KIND_TICK:  state_next = clt_pkg::ST_TICK_CHK;
          default:             state_next = clt_pkg::ST_DONE;
        endcase
      end
      clt_pkg::ST_SYNC_A:  state_next = clt_pkg::ST_SYNC_B;
      clt_pkg::ST_SYNC_B:  state_next = clt_pkg::ST_DONE;
      clt_pkg::ST_FRAME_A: state_next = clt_pkg::ST_FRAME_B;
      clt_pkg::ST_FRAME_B: state_next = clt_pkg::ST_FRAME_C;
      clt_pkg::ST_FRAME_C: state_next = clt_pkg::ST_DONE;
      clt_pkg::ST_TICK_CHK: begin
        state_next = stat.count_zero ? clt_pkg::ST_DONE : clt_pkg::ST_TICK_MUL;
      end
      clt_pkg::ST_TICK_MUL: begin
        if (cnt == '0) state_next = clt_pkg::ST_DIV_INIT;
      end
      clt_pkg::ST_DIV_INIT: state_next = clt_pkg::ST_TICK_DIV;
      clt_pkg::ST_TICK_DIV: begin
        if (cnt == '0) state_next = clt_pkg::ST_TICK_END;
      end
      clt_pkg::ST_TICK_END: state_next = clt_pkg::ST_DONE;
      clt_pkg::ST_DONE: begin
        if (!stat.out_busy) state_next = clt_pkg::ST_IDLE;
      end
      default: state_next = clt_pkg::ST_IDLE;
    endcase
  end

  // outputs and step counter
  always_comb begin
    in_ready = 1'b0;
    cmd.op = clt_pkg::OP_NONE;
    cmd.idx = cnt[clt_pkg::MS_IDX_W-1:0];
    cnt_next = cnt;
    unique case (state)
      clt_pkg::ST_IDLE: begin
        // no request is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) cmd.op = clt_pkg::OP_LOAD;
      end
      clt_pkg::ST_DISPATCH: cmd.op = clt_pkg::OP_NONE;
      clt_pkg::ST_SYNC_A:   cmd.op = clt_pkg::OP_SYNC_A;
      clt_pkg::ST_SYNC_B:   cmd.op = clt_pkg::OP_SYNC_B;
      clt_pkg::ST_FRAME_A:  cmd.op = clt_pkg::OP_FRAME_A;
      clt_pkg::ST_FRAME_B:  cmd.op = clt_pkg::OP_FRAME_B;
      clt_pkg::ST_FRAME_C:  cmd.op = clt_pkg::OP_FRAME_C;
      clt_pkg::ST_TICK_CHK: begin
        if (!stat.count_zero) begin
          cmd.op = clt_pkg::OP_TICK_START;
          cnt_next = clt_pkg::STEP_W'(clt_pkg::MS_BITS - 1);
        end
      end
      clt_pkg::ST_TICK_MUL: begin
        cmd.op = clt_pkg::OP_MUL_STEP;
        cnt_next = cnt - 1'b1;
      end
      clt_pkg::ST_DIV_INIT: begin
        cmd.op = clt_pkg::OP_DIV_INIT;
        cnt_next = clt_pkg::STEP_W'(clt_pkg::SUM_W - 1);
      end
      clt_pkg::ST_TICK_DIV: begin
        cmd.op = clt_pkg::OP_DIV_STEP;
        cnt_next = cnt - 1'b1;
      end
      clt_pkg::ST_TICK_END: cmd.op = clt_pkg::OP_TICK_END;
      clt_pkg::ST_DONE: begin
        if (!stat.out_busy) cmd.op = clt_pkg::OP_OUT_LOAD;
      end
      default: cmd.op = clt_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/clt_dp.sv =====
// datapath: offset filter, latency accumulator, shift-add divisor build,
// restoring divider and output register; depends on clt_pkg
`default_nettype none

module clt_dp #(
  parameter int COUNT_WIDTH = clt_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire clt_pkg::cmd_t                cmd,
  output clt_pkg::stat_t                    stat,
  input  wire logic                         cfg_valid,
  input  wire logic [clt_pkg::STALE_W-1:0]  cfg_data,
  input  wire logic [1:0]                   kind,
  input  wire logic [clt_pkg::TIME_W-1:0]   sent_time,
  input  wire logic [clt_pkg::TIME_W-1:0]   remote_time,
  input  wire logic [clt_pkg::TIME_W-1:0]   local_time,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              offset_valid,
  output logic signed [clt_pkg::SUM_W-1:0]  clock_offset,
  output logic [clt_pkg::MEAN_W-1:0]        mean_latency_ms,
  output logic                              mean_updated
);

  localparam int SW = clt_pkg::SUM_W;
  localparam int DW = COUNT_WIDTH + clt_pkg::MS_BITS;

  // request registers
  logic [1:0] kind_r;
  logic [clt_pkg::TIME_W-1:0] sent_r, remote_r, local_r;

  // held state
  logic [clt_pkg::STALE_W-1:0] stale_limit;
  logic offset_held;
  logic [SW-1:0] best_offset, best_rtt, offset_stamp, lat_sum;
  logic [COUNT_WIDTH-1:0] sample_count;
  logic [clt_pkg::MEAN_W-1:0] last_mean;
  logic updated;

  // work registers
  logic fwd;
  logic [SW-1:0] rtt, mid, age, lat_d, lat;
  logic [DW-1:0] divisor, rem;
  logic [SW-1:0] quo;

  logic [SW-1:0] off;
  logic take;
  logic [SW:0] lat_full, sum_full;
  logic [DW:0] rem_sh;
  logic rem_ge;
  logic [DW-1:0] mul_add;
  logic [clt_pkg::MEAN_W-1:0] mean_sat;

  always_comb begin
    off = {1'b0, remote_r} - mid;
    take = !offset_held || (rtt <= best_rtt)
           || (age > {{(SW - clt_pkg::STALE_W){1'b0}}, stale_limit});
    lat_full = {lat_d[SW-1], lat_d} + {best_offset[SW-1], best_offset};
    sum_full = {1'b0, lat_sum} + {1'b0, lat};
    rem_sh = {rem, quo[SW-1]};
    rem_ge = rem_sh >= {1'b0, divisor};
    mul_add = clt_pkg::NS_PER_MS[cmd.idx] ? DW'(sample_count) : '0;
    mean_sat = (|quo[SW-1:clt_pkg::MEAN_W]) ? '1 : quo[clt_pkg::MEAN_W-1:0];
  end

  always_comb begin
    stat.kind = kind_r;
    stat.count_zero = (sample_count == '0);
    stat.out_busy = out_valid && !out_ready;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= clt_pkg::STALE_RESET;
      offset_held <= 1'b0;
      best_offset <= '0;
      best_rtt <= '0;
      offset_stamp <= '0;
      lat_sum <= '0;
      sample_count <= '0;
      last_mean <= '0;
      updated <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) stale_limit <= cfg_data;
      if (cmd.op == clt_pkg::OP_OUT_LOAD) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (cmd.op)
        clt_pkg::OP_LOAD: updated <= 1'b0;
        clt_pkg::OP_SYNC_B: begin
          if (fwd && take) begin
            offset_held <= 1'b1;
            best_offset <= off;
            best_rtt <= rtt;
            offset_stamp <= {1'b0, local_r};
          end
        end
        clt_pkg::OP_FRAME_C: begin
          if (offset_held) begin
            lat_sum <= sum_full[SW] ? '1 : sum_full[SW-1:0];
            if (!(&sample_count)) sample_count <= sample_count + 1'b1;
          end
        end
        clt_pkg::OP_TICK_END: begin
          last_mean <= mean_sat;
          lat_sum <= '0;
          sample_count <= '0;
          updated <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      clt_pkg::OP_LOAD: begin
        kind_r <= kind;
        sent_r <= sent_time;
        remote_r <= remote_time;
        local_r <= local_time;
      end
      clt_pkg::OP_SYNC_A: begin
        fwd <= local_r > sent_r;
        rtt <= {1'b0, local_r} - {1'b0, sent_r};
        mid <= SW'(({1'b0, sent_r} + {1'b0, local_r}) >> 1);
        age <= {1'b0, local_r} - offset_stamp;
      end
      clt_pkg::OP_FRAME_A: lat_d <= {1'b0, local_r} - {1'b0, remote_r};
      // negative latency clamps to zero
      clt_pkg::OP_FRAME_B: lat <= lat_full[SW] ? '0 : lat_full[SW-1:0];
      clt_pkg::OP_TICK_START: divisor <= '0;
      // divisor = count * ns_per_ms, msb first
      clt_pkg::OP_MUL_STEP: divisor <= {divisor[DW-2:0], 1'b0} + mul_add;
      clt_pkg::OP_DIV_INIT: begin
        rem <= '0;
        quo <= lat_sum;
      end
      clt_pkg::OP_DIV_STEP: begin
        rem <= rem_ge ? DW'(rem_sh - {1'b0, divisor}) : rem_sh[DW-1:0];
        quo <= {quo[SW-2:0], rem_ge};
      end
      clt_pkg::OP_OUT_LOAD: begin
        offset_valid <= offset_held;
        clock_offset <= best_offset;
        mean_latency_ms <= last_mean;
        mean_updated <= updated;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/clock_offset_latency_tracker.sv =====
// Clock offset and frame latency tracker. Takes one request at a time and
// returns one result per request through an output register, so a new
// request is taken while the last result still waits. A sync reply runs the
// SYNC_A and SYNC_B steps and a frame the FRAME_A, FRAME_B and FRAME_C steps;
// a report tick with samples runs the 20-step shift-add that forms count
// times one million and the 64-step restoring divider of the sum by that
// product, and a tick without samples skips both. Depends on clt_pkg,
// clt_ctrl, clt_dp and the assertion macro header.
`default_nettype none
`include "clock_offset_latency_tracker_macros.svh"

module clock_offset_latency_tracker #(
  parameter int COUNT_WIDTH = clt_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [clt_pkg::STALE_W-1:0]  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   kind,
  input  wire logic [clt_pkg::TIME_W-1:0]   sent_time,
  input  wire logic [clt_pkg::TIME_W-1:0]   remote_time,
  input  wire logic [clt_pkg::TIME_W-1:0]   local_time,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              offset_valid,
  output logic signed [clt_pkg::SUM_W-1:0]  clock_offset,
  output logic [clt_pkg::MEAN_W-1:0]        mean_latency_ms,
  output logic                              mean_updated
);

  clt_pkg::cmd_t cmd;
  clt_pkg::stat_t stat;

  assign cfg_ready = !rst;

  clt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clt_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .sent_time       (sent_time),
    .remote_time     (remote_time),
    .local_time      (local_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .offset_valid    (offset_valid),
    .clock_offset    (clock_offset),
    .mean_latency_ms (mean_latency_ms),
    .mean_updated    (mean_updated)
  );

  // one request in flight at a time
  `CLT_ASSERT_NXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  // a pending result is never overwritten
  `CLT_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.op == clt_pkg::OP_OUT_LOAD,
                  !out_valid || out_ready)
  // once an offset is reported it stays reported
  `CLT_ASSERT_NXT(a_offset_sticky, clk, rst, out_valid && out_ready && offset_valid,
                  !out_valid || offset_valid)

endmodule

`default_nettype wire
